// ===== rtl/ctb_pkg.sv =====
// Shared codes, widths and cell interface types for the countdown timer bank.
package ctb_pkg;

  localparam int unsigned DefNumTimers  = 16;
  localparam int unsigned DefCountWidth = 32;

  localparam int unsigned ActionW = 3;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned TicksW  = 32;
  localparam int unsigned KindW   = 2;

  // Timer 0 is reserved; allocation starts here.
  localparam int unsigned FirstUserId = 0 + 1;

  localparam logic [ActionW-1:0] ACT_ALLOC   = 3'd0;
  localparam logic [ActionW-1:0] ACT_START   = 3'd1;
  localparam logic [ActionW-1:0] ACT_LOAD    = 3'd2;
  localparam logic [ActionW-1:0] ACT_STOP    = 3'd3;
  localparam logic [ActionW-1:0] ACT_RESUME  = 3'd4;
  localparam logic [ActionW-1:0] ACT_QUERY   = 3'd5;
  localparam logic [ActionW-1:0] ACT_TICK    = 3'd6;
  localparam logic [ActionW-1:0] ACT_RUN_ALL = 3'd7;

  localparam logic [KindW-1:0] KIND_ACK    = 2'd0;
  localparam logic [KindW-1:0] KIND_ID     = 2'd1;
  localparam logic [KindW-1:0] KIND_STATUS = 2'd2;
  localparam logic [KindW-1:0] KIND_EXPIRY = 2'd3;

  // Command broadcast to every cell.
  typedef struct packed {
    logic               apply;
    logic [ActionW-1:0] action;
    logic [IndexW-1:0]  index;
    logic [TicksW-1:0]  ticks;
    logic               mode;
    logic               notify;
    logic               run_flag;
  } ctb_cmd_t;

  // Status a cell reports back.
  typedef struct packed {
    logic ev;
    logic expired;
    logic running;
  } ctb_stat_t;

endpackage

// ===== rtl/ctb_cell.sv =====
// One timer of the bank: its count, period and flags, plus the tick token stage.
module ctb_cell import ctb_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = DefCountWidth,
  parameter int unsigned CELL_ID     = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctb_cmd_t  cmd_i,
  input  logic      alloc_i,
  input  logic      step_i,
  input  logic      tok_i,
  output logic      tok_o,
  output ctb_stat_t stat_o
);

  logic [COUNT_WIDTH-1:0] period_q, period_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [COUNT_WIDTH-1:0] count_dec;
  logic                   periodic_q, periodic_d;
  logic                   notify_q, notify_d;
  logic                   running_q, running_d;
  logic                   expired_q, expired_d;
  logic                   tok_q;
  logic                   match;
  logic                   hit_zero;

  assign match     = (32'(cmd_i.index) == 32'(CELL_ID));
  assign count_dec = count_q - COUNT_WIDTH'(1);
  assign hit_zero  = (count_dec == '0);

  always_comb begin
    period_d   = period_q;
    count_d    = count_q;
    periodic_d = periodic_q;
    notify_d   = notify_q;
    running_d  = running_q;
    expired_d  = expired_q;
    if (cmd_i.apply) begin
      case (cmd_i.action)
        ACT_START: begin
          if (match && alloc_i) begin
            expired_d  = 1'b0;
            periodic_d = cmd_i.mode;
            period_d   = COUNT_WIDTH'(cmd_i.ticks);
            count_d    = COUNT_WIDTH'(cmd_i.ticks);
            notify_d   = cmd_i.notify;
            running_d  = 1'b1;
          end
        end
        ACT_LOAD: begin
          if (match) begin
            period_d = COUNT_WIDTH'(cmd_i.ticks);
            count_d  = COUNT_WIDTH'(cmd_i.ticks);
          end
        end
        ACT_STOP: begin
          if (match) running_d = 1'b0;
        end
        ACT_RESUME: begin
          if (match) running_d = 1'b1;
        end
        ACT_RUN_ALL: begin
          if (alloc_i) running_d = cmd_i.run_flag;
        end
        default: begin
        end
      endcase
    end else if (step_i && tok_q && running_q) begin
      // Decrement on token; reload or stop on reaching zero.
      count_d = count_dec;
      if (hit_zero) begin
        expired_d = 1'b1;
        if (periodic_q) count_d = period_q;
        else running_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= '0;
      count_q    <= '0;
      periodic_q <= 1'b0;
      notify_q   <= 1'b0;
      running_q  <= 1'b0;
      expired_q  <= 1'b0;
      tok_q      <= 1'b0;
    end else begin
      period_q   <= period_d;
      count_q    <= count_d;
      periodic_q <= periodic_d;
      notify_q   <= notify_d;
      running_q  <= running_d;
      expired_q  <= expired_d;
      if (step_i) tok_q <= tok_i;
    end
  end

  assign tok_o          = tok_q;
  assign stat_o.ev      = tok_q && running_q && notify_q && hit_zero;
  assign stat_o.expired = expired_q;
  assign stat_o.running = running_q;

endmodule

// ===== rtl/countdown_timer_bank_core.sv =====
// Top level of the countdown timer bank: command sequencer, cell chain, result register.
//
// A bank of NUM_TIMERS countdown timers, one per cell in a chain. Timer ids are handed out
// from 1 upward; timer 0 is reserved. Every input item yields results ending in one with
// tlast high. Allocate, start, load, stop, resume, query and set-all-running go from the
// execute state into the result register once it is free. A tick walks a token down the
// cell chain one cell per cycle while the result register is free, each cell updating its
// timer as the token passes and emitting at most one expiry item; an ack closes the tick.
// One item is in work at a time; the next is accepted while the last result still waits
// in the output register. Count and period reset to zero.
module countdown_timer_bank_core import ctb_pkg::*; #(
  parameter int unsigned NUM_TIMERS  = DefNumTimers,
  parameter int unsigned COUNT_WIDTH = DefCountWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // [3:0] timer_index, [35:4] ticks, [36] mode, [37] notify, [38] run_flag
  input  logic [39:0]        s_axis_tdata_i,
  // [2:0] action
  input  logic [ActionW-1:0] s_axis_tuser_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // [3:0] timer_id, [4] id_valid, [5] expired, [6] running
  output logic [7:0]         m_axis_tdata_o,
  // [1:0] kind
  output logic [KindW-1:0]   m_axis_tuser_o,
  output logic               m_axis_tlast_o
);

  localparam int unsigned AllocW = $clog2(NUM_TIMERS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_TICK = 2'd2;
  localparam logic [1:0] S_ACK  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic               first_q, first_d;
  logic [AllocW-1:0]  alloc_q;
  logic               alloc_inc;

  logic [ActionW-1:0] act_q;
  logic [IndexW-1:0]  idx_q;
  logic [TicksW-1:0]  ticks_q;
  logic               mode_q, notify_q, run_q;

  logic               out_valid_q;
  logic [KindW-1:0]   out_kind_q, out_kind_d;
  logic [IndexW-1:0]  out_id_q, out_id_d;
  logic               out_idv_q, out_idv_d;
  logic               out_exp_q, out_exp_d;
  logic               out_run_q, out_run_d;
  logic               out_last_q, out_last_d;
  logic               out_load;
  logic               out_free;

  logic               in_acc;
  logic               apply;
  logic               step;
  ctb_cmd_t           cmd;

  logic [NUM_TIMERS:0]   tok_chain;
  logic [NUM_TIMERS-1:0] alloc_vec;
  logic [NUM_TIMERS-1:0] ev_vec;
  logic [NUM_TIMERS-1:0] exp_vec;
  logic [NUM_TIMERS-1:0] run_vec;
  logic [15:0]           exp16, run16;
  logic                  ev_any;
  logic [IndexW-1:0]     ev_id;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign cmd.apply    = apply;
  assign cmd.action   = act_q;
  assign cmd.index    = idx_q;
  assign cmd.ticks    = ticks_q;
  assign cmd.mode     = mode_q;
  assign cmd.notify   = notify_q;
  assign cmd.run_flag = run_q;

  assign tok_chain[0] = first_q;

  for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
    ctb_stat_t stat;

    assign alloc_vec[k] = (AllocW'(k) < alloc_q);

    ctb_cell #(
      .COUNT_WIDTH(COUNT_WIDTH),
      .CELL_ID    (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .alloc_i(alloc_vec[k]),
      .step_i (step),
      .tok_i  (tok_chain[k]),
      .tok_o  (tok_chain[k+1]),
      .stat_o (stat)
    );

    assign ev_vec[k]  = stat.ev;
    assign exp_vec[k] = stat.expired;
    assign run_vec[k] = stat.running;
  end

  // Pad the flag rows to the index range; entries beyond the bank read as zero.
  for (genvar k = 0; k < 16; k++) begin : g_pad
    if (k < NUM_TIMERS) begin : g_in
      assign exp16[k] = exp_vec[k];
      assign run16[k] = run_vec[k];
    end else begin : g_out
      assign exp16[k] = 1'b0;
      assign run16[k] = 1'b0;
    end
  end

  assign ev_any = |ev_vec;

  always_comb begin
    ev_id = '0;
    for (int k = 0; k < NUM_TIMERS; k++) begin
      if (ev_vec[k]) ev_id = IndexW'(k);
    end
  end

  always_comb begin
    state_d    = state_q;
    first_d    = first_q;
    out_load   = 1'b0;
    out_kind_d = KIND_ACK;
    out_id_d   = '0;
    out_idv_d  = 1'b0;
    out_exp_d  = 1'b0;
    out_run_d  = 1'b0;
    out_last_d = 1'b1;
    apply      = 1'b0;
    step       = 1'b0;
    alloc_inc  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          // Only a tick launches the token.
          first_d = (s_axis_tuser_i == ACT_TICK);
          state_d = (s_axis_tuser_i == ACT_TICK) ? S_TICK : S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_load = 1'b1;
          apply    = 1'b1;
          state_d  = S_IDLE;
          case (act_q)
            ACT_ALLOC: begin
              out_kind_d = KIND_ID;
              if (32'(alloc_q) < NUM_TIMERS) begin
                out_id_d  = IndexW'(alloc_q);
                out_idv_d = 1'b1;
                alloc_inc = 1'b1;
              end
            end
            ACT_QUERY: begin
              out_kind_d = KIND_STATUS;
              out_id_d   = idx_q;
              out_exp_d  = exp16[idx_q];
              out_run_d  = run16[idx_q];
            end
            default: begin
              out_id_d = idx_q;
            end
          endcase
        end
      end
      S_TICK: begin
        if (out_free) begin
          step    = 1'b1;
          first_d = 1'b0;
          if (ev_any) begin
            out_load   = 1'b1;
            out_kind_d = KIND_EXPIRY;
            out_id_d   = ev_id;
            out_last_d = 1'b0;
          end
          if (tok_chain[NUM_TIMERS]) state_d = S_ACK;
        end
      end
      S_ACK: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q    <= s_axis_tuser_i;
      idx_q    <= s_axis_tdata_i[3:0];
      ticks_q  <= s_axis_tdata_i[35:4];
      mode_q   <= s_axis_tdata_i[36];
      notify_q <= s_axis_tdata_i[37];
      run_q    <= s_axis_tdata_i[38];
    end
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_id_q   <= out_id_d;
      out_idv_q  <= out_idv_d;
      out_exp_q  <= out_exp_d;
      out_run_q  <= out_run_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      first_q     <= 1'b0;
      alloc_q     <= AllocW'(FirstUserId);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
      if (alloc_inc) alloc_q <= alloc_q + AllocW'(1);
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_run_q, out_exp_q, out_idv_q, out_id_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  a_tok_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_chain))
    else $error("tick token held by more than one cell");

  a_ev_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(ev_vec))
    else $error("more than one expiry raised in one step");

  a_idle_no_tok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (tok_chain == '0))
    else $error("token still in chain while idle");

  a_alloc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(alloc_q) <= NUM_TIMERS)
    else $error("allocation count beyond bank size");

  a_ack_after_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TICK && step && tok_chain[NUM_TIMERS]) |=> (state_q == S_ACK))
    else $error("tick did not close after last cell");

endmodule

// ===== dv/tb_countdown_timer_bank_core.sv =====
// Testbench for countdown_timer_bank_core: directed and random streams checked against a predictor.
`timescale 1ns / 1ps

module tb_countdown_timer_bank_core import ctb_pkg::*; ();

  localparam int unsigned NumTimers  = DefNumTimers;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned TailCycles = NumTimers + 24;
  localparam int unsigned RandItems  = 100;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [IndexW-1:0]  index;
    logic [TicksW-1:0]  ticks;
    logic               mode;
    logic               notify;
    logic               run_flag;
  } timer_cmd_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [3:0]       timer_id;
    logic             id_valid;
    logic             expired;
    logic             running;
    logic             last;
  } timer_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_valid = 1'b0;
  logic               s_ready;
  logic [39:0]        s_tdata = '0;
  logic [ActionW-1:0] s_tuser = ACT_QUERY;
  logic               m_valid;
  logic               m_ready = 1'b0;
  logic [7:0]         m_tdata;
  logic [KindW-1:0]   m_tuser;
  logic               m_tlast;

  // Predicted bank state
  logic [TicksW-1:0] period_q [NumTimers];
  logic [TicksW-1:0] count_q  [NumTimers];
  bit                periodic_q [NumTimers];
  bit                notify_q   [NumTimers];
  bit                running_q  [NumTimers];
  bit                expired_q  [NumTimers];
  int unsigned       alloc_cnt;

  timer_result_t due_results[$];
  int unsigned   err_count = 0;
  int unsigned   cycle_count = 0;
  bit            tx_calm = 1'b0;
  bit            rx_calm = 1'b0;
  int unsigned   rx_stall = 0;
  int unsigned   rx_gap;

  always #5 clk_i = ~clk_i;

  countdown_timer_bank_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  function automatic int unsigned draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic void push_result(logic [KindW-1:0] kind, int unsigned id,
                                      bit valid, bit exp, bit run, bit last);
    timer_result_t r;
    r.kind     = kind;
    r.timer_id = id[3:0];
    r.id_valid = valid;
    r.expired  = exp;
    r.running  = run;
    r.last     = last;
    due_results.push_back(r);
  endfunction

  function automatic void clear_bank();
    for (int i = 0; i < NumTimers; i++) begin
      period_q[i]   = '0;
      count_q[i]    = '0;
      periodic_q[i] = 1'b0;
      notify_q[i]   = 1'b0;
      running_q[i]  = 1'b0;
      expired_q[i]  = 1'b0;
    end
    alloc_cnt = FirstUserId;
  endfunction

  // Advance the predicted bank by one accepted item and queue what it should produce.
  function automatic void timer_bank_step(timer_cmd_t c);
    int unsigned idx;
    idx = c.index;
    case (c.action)
      ACT_ALLOC: begin
        if (alloc_cnt >= NumTimers) begin
          push_result(KIND_ID, 0, 1'b0, 1'b0, 1'b0, 1'b1);
        end else begin
          push_result(KIND_ID, alloc_cnt, 1'b1, 1'b0, 1'b0, 1'b1);
          alloc_cnt++;
        end
      end
      ACT_START: begin
        if (idx < alloc_cnt) begin
          expired_q[idx]  = 1'b0;
          periodic_q[idx] = c.mode;
          period_q[idx]   = c.ticks;
          count_q[idx]    = c.ticks;
          notify_q[idx]   = c.notify;
          running_q[idx]  = 1'b1;
        end
        push_result(KIND_ACK, idx, 1'b0, 1'b0, 1'b0, 1'b1);
      end
      ACT_LOAD: begin
        period_q[idx] = c.ticks;
        count_q[idx]  = c.ticks;
        push_result(KIND_ACK, idx, 1'b0, 1'b0, 1'b0, 1'b1);
      end
      ACT_STOP: begin
        running_q[idx] = 1'b0;
        push_result(KIND_ACK, idx, 1'b0, 1'b0, 1'b0, 1'b1);
      end
      ACT_RESUME: begin
        running_q[idx] = 1'b1;
        push_result(KIND_ACK, idx, 1'b0, 1'b0, 1'b0, 1'b1);
      end
      ACT_QUERY: begin
        push_result(KIND_STATUS, idx, 1'b0, expired_q[idx], running_q[idx], 1'b1);
      end
      ACT_TICK: begin
        for (int i = 0; i < NumTimers; i++) begin
          if (running_q[i]) begin
            count_q[i] = count_q[i] - 1'b1;
            if (count_q[i] == '0) begin
              expired_q[i] = 1'b1;
              if (notify_q[i]) push_result(KIND_EXPIRY, i, 1'b0, 1'b0, 1'b0, 1'b0);
              if (periodic_q[i]) count_q[i] = period_q[i];
              else running_q[i] = 1'b0;
            end
          end
        end
        push_result(KIND_ACK, 0, 1'b0, 1'b0, 1'b0, 1'b1);
      end
      default: begin
        for (int i = 0; i < alloc_cnt && i < NumTimers; i++) running_q[i] = c.run_flag;
        push_result(KIND_ACK, idx, 1'b0, 1'b0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  function automatic timer_cmd_t make_cmd(logic [ActionW-1:0] action, int unsigned idx,
                                          logic [TicksW-1:0] ticks, bit mode = 1'b0,
                                          bit notify = 1'b0, bit run = 1'b0);
    timer_cmd_t c;
    c.action   = action;
    c.index    = idx[IndexW-1:0];
    c.ticks    = ticks;
    c.mode     = mode;
    c.notify   = notify;
    c.run_flag = run;
    return c;
  endfunction

  task automatic send_item(timer_cmd_t c);
    int unsigned gap;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_tdata <= {1'b0, c.run_flag, c.notify, c.mode, c.ticks, c.index};
    s_tuser <= c.action;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    timer_bank_step(c);
  endtask

  // Hold the sender until the bank has delivered everything it owes.
  task automatic drain_results();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic void check_result();
    timer_result_t want;
    if (due_results.size() == 0) begin
      $error("unexpected item: kind %0d timer_id %0d", m_tuser, m_tdata[3:0]);
      err_count++;
      return;
    end
    want = due_results.pop_front();
    if (m_tuser !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, m_tuser);
      err_count++;
    end
    if (m_tdata[3:0] !== want.timer_id) begin
      $error("timer_id: expected %0d, got %0d", want.timer_id, m_tdata[3:0]);
      err_count++;
    end
    if (m_tdata[4] !== want.id_valid) begin
      $error("id_valid: expected %0d, got %0d", want.id_valid, m_tdata[4]);
      err_count++;
    end
    if (m_tdata[5] !== want.expired) begin
      $error("expired: expected %0d, got %0d", want.expired, m_tdata[5]);
      err_count++;
    end
    if (m_tdata[6] !== want.running) begin
      $error("running: expected %0d, got %0d", want.running, m_tdata[6]);
      err_count++;
    end
    if (m_tlast !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, m_tlast);
      err_count++;
    end
  endfunction

  // Receiver: check each accepted item, then stall a random number of cycles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready  <= 1'b0;
      rx_stall <= 0;
    end else if (m_valid && m_ready) begin
      check_result();
      rx_gap = draw_gap(rx_calm);
      rx_stall <= rx_gap;
      m_ready  <= (rx_gap == 0);
    end else if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      if (rx_stall == 1) m_ready <= 1'b1;
    end else begin
      m_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_countdown_timer_bank_core failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(make_cmd(ACT_QUERY, 3, '0));
    send_item(make_cmd(ACT_START, 3, 32'd5, 1'b1, 1'b1));   // unallocated: ignored
    send_item(make_cmd(ACT_START, 0, 32'd2, 1'b1, 1'b1));   // reserved timer may start
    send_item(make_cmd(ACT_TICK, 0, '0));
    send_item(make_cmd(ACT_TICK, 0, '0));
    send_item(make_cmd(ACT_QUERY, 0, '0));
    send_item(make_cmd(ACT_ALLOC, 0, '0));
    send_item(make_cmd(ACT_START, 1, 32'd1, 1'b0, 1'b1));
    send_item(make_cmd(ACT_TICK, 0, '0));
    send_item(make_cmd(ACT_QUERY, 1, '0));
    send_item(make_cmd(ACT_START, 1, '0));                  // zero period wraps
    send_item(make_cmd(ACT_TICK, 0, '0));
    send_item(make_cmd(ACT_QUERY, 1, '0));
    send_item(make_cmd(ACT_LOAD, 15, 32'hFFFF_FFFF));
    send_item(make_cmd(ACT_RESUME, 15, '0));
    send_item(make_cmd(ACT_TICK, 0, '0));
    send_item(make_cmd(ACT_STOP, 15, '0));
    send_item(make_cmd(ACT_QUERY, 15, '0));
    send_item(make_cmd(ACT_RUN_ALL, 0, '0, 1'b0, 1'b0, 1'b0));
    send_item(make_cmd(ACT_QUERY, 0, '0));
    send_item(make_cmd(ACT_RUN_ALL, 2, '0, 1'b1, 1'b1, 1'b1));
    send_item(make_cmd(ACT_LOAD, 1, 32'd1));
    send_item(make_cmd(ACT_TICK, 0, '0));
    send_item(make_cmd(ACT_STOP, 0, '0));
    drain_results();
  endtask

  function automatic timer_cmd_t random_cmd();
    int unsigned       pick;
    int unsigned       idx;
    logic [TicksW-1:0] ticks;
    logic [ActionW-1:0] action;
    pick = $urandom_range(0, 99);
    if (pick < 30)      action = ACT_TICK;
    else if (pick < 46) action = ACT_START;
    else if (pick < 60) action = ACT_QUERY;
    else if (pick < 68) action = ACT_LOAD;
    else if (pick < 75) action = ACT_STOP;
    else if (pick < 82) action = ACT_RESUME;
    else if (pick < 88) action = ACT_RUN_ALL;
    else                action = ACT_ALLOC;
    if (alloc_cnt > 1 && $urandom_range(0, 4) != 0) idx = $urandom_range(0, alloc_cnt - 1);
    else idx = $urandom_range(0, NumTimers - 1);
    case ($urandom_range(0, 9))
      0:       ticks = '0;
      1:       ticks = '1;
      2, 3:    ticks = $urandom();
      default: ticks = $urandom_range(1, 6);
    endcase
    return make_cmd(action, idx, ticks, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
  endfunction

  task automatic test_random_traffic(int unsigned n);
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) begin
        tx_calm = ($urandom_range(0, 2) == 0);
        rx_calm = ($urandom_range(0, 2) == 0);
      end
      if ($urandom_range(0, 29) == 0) drain_results();
      send_item(random_cmd());
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    drain_results();
  endtask

  // Fill the bank, overflow it, then make every timer expire on the same tick.
  task automatic test_bank_full();
    while (alloc_cnt < NumTimers) send_item(make_cmd(ACT_ALLOC, 0, '0));
    send_item(make_cmd(ACT_ALLOC, 0, '0));
    send_item(make_cmd(ACT_ALLOC, 0, '0));
    for (int i = 0; i < NumTimers; i++) send_item(make_cmd(ACT_START, i, 32'd1, 1'b1, 1'b1));
    send_item(make_cmd(ACT_TICK, 0, '0));
    send_item(make_cmd(ACT_TICK, 0, '0));
    send_item(make_cmd(ACT_RUN_ALL, 7, '0, 1'b0, 1'b0, 1'b0));
    send_item(make_cmd(ACT_QUERY, 15, '0));
    drain_results();
  endtask

  initial begin
    clear_bank();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_traffic(RandItems);
    test_bank_full();
    test_random_traffic(RandItems);
    repeat (TailCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_countdown_timer_bank_core passed");
    end else begin
      $display("tb_countdown_timer_bank_core failed");
    end
    $finish;
  end

endmodule
